// ===== sv/bpa_pkg.sv =====
// shared types and constants for the bitmap page allocator
`default_nettype none

package bpa_pkg;

	localparam int WORD_BITS = 32;
	localparam int BIT_W     = 5;

	localparam logic [15:0] COUNT_MAX         = 16'hFFFF;
	localparam logic [15:0] TOTAL_PAGES_RESET = 16'd32768;

	typedef enum logic [1:0] {
		REQ_ALLOC       = 2'd0,
		REQ_FREE        = 2'd1,
		REQ_FREE_REGION = 2'd2,
		REQ_RESERVE     = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		STAT_DONE    = 2'd0,
		STAT_NO_FREE = 2'd1,
		STAT_BEYOND  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_SETUP,
		ST_WALK,
		ST_PUSH
	} state_t;

	// bit range of one map entry and the operation to apply to it
	typedef struct packed {
		req_t             op;
		logic [BIT_W-1:0] lo;
		logic [BIT_W-1:0] hi;
	} word_cmd_t;

	typedef struct packed {
		logic                 found;
		logic [BIT_W-1:0]     idx;
		logic [WORD_BITS-1:0] word;
	} word_res_t;

endpackage

`default_nettype wire

// ===== sv/bitmap_page_allocator_unit.sv =====
// bitmap page allocator: first-fit page alloc, page free, region free and reserve
// channels: cfg (total_pages write), in (one request word), out (one result word)
// every channel moves a word when its valid and ready are both high
// the used map lives in a synchronous memory of 32-bit entries, one bit a page
// a request walks the entries it touches, one entry a cycle: read, modify, write
// after acceptance a request passes the prep and setup states, walks its n entries
// (none for a free past the store or an empty range) and waits in the push state
// until its result is loaded into the output register
// alloc walks up to ceil(min(total_pages, MAX_PAGES) / 32) entries and stops at
// the first free page; free page walks one; regions walk the entries they cover
// one request is in flight at a time, the next is taken once the result is
// queued in the output register, even if the receiver has not yet taken it
// a stalled receiver holds the output register and a finished request waits
// in its push state until the register empties
// after reset a clearing pass marks every page used, writing all ceil(MAX_PAGES/32)
// entries with in_ready low; the used count resets to zero, total_pages to 32768
// configuration writes are always taken; PAGE_BYTES must be a power of two
`default_nettype none

module bitmap_page_allocator_unit #(
	parameter int MAX_PAGES  = 32768,
	parameter int PAGE_BYTES = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [31:0] byte_address,
	input  logic [31:0] region_len,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] page_address,
	output logic [1:0]  status,
	output logic [15:0] used_count
);
	import bpa_pkg::*;

	localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int PB_LOG    = $clog2(PAGE_BYTES);
	// page numbers must hold both a byte address over page size and MAX_PAGES
	localparam int PN_A      = 33 - PB_LOG;
	localparam int PN_B      = $clog2(MAX_PAGES + 1);
	localparam int PN_W      = (PN_A > PN_B) ? PN_A : PN_B;

	localparam logic [WA_W-1:0] LAST_WORD = WA_W'(MAP_WORDS - 1);
	localparam logic [PN_W-1:0] MAX_PG    = PN_W'(MAX_PAGES);
	localparam logic [32:0]     PB_M1     = 33'(PAGE_BYTES - 1);

	// control state
	state_t      st_q, st_d;
	logic [WA_W-1:0] clr_q;
	logic [15:0] used_q;
	logic [15:0] total_q;
	logic        out_valid_q;

	// request registers
	req_t        req_q;
	logic [31:0] addr_q;
	logic [31:0] len_q;
	logic [31:0] end_q;
	logic [PN_W-1:0] first_q;
	logic [PN_W-1:0] stop_m1_q;
	logic [WA_W-1:0] cur_q;
	logic [31:0] res_addr_q;
	status_t     res_status_q;

	// output register
	logic [31:0] page_address_q;
	logic [1:0]  status_q;
	logic [15:0] used_count_q;

	// map memory
	logic [WORD_BITS-1:0] map_mem [MAP_WORDS];
	logic [WORD_BITS-1:0] map_rdata_q;
	logic                 mem_we, mem_re;
	logic [WA_W-1:0]      mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata;

	logic in_acc, push_ok;

	assign cfg_ready    = 1'b1;
	assign in_ready     = (st_q == ST_IDLE);
	assign in_acc       = in_valid && in_ready;
	assign push_ok      = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign page_address = page_address_q;
	assign status       = status_q;
	assign used_count   = used_count_q;

	// range setup: first page and clipped stop page of the request
	logic [32:0]     sum33;
	logic [32:0]     addr_up, end_up;
	logic [PN_W-1:0] set_first, set_stop_raw, set_stop, set_stop_m1;
	logic            set_beyond, set_empty;
	logic [WA_W-1:0] set_first_w;

	assign sum33   = {1'b0, addr_q} + {1'b0, len_q};
	assign addr_up = {1'b0, addr_q} + PB_M1;
	assign end_up  = {1'b0, end_q} + PB_M1;

	always_comb begin
		set_first    = PN_W'(addr_q >> PB_LOG);
		set_stop_raw = set_first + 1'b1;
		set_beyond   = 1'b0;
		case (req_q)
			REQ_ALLOC: begin
				set_first    = '0;
				set_stop_raw = PN_W'(total_q);
			end
			REQ_FREE: begin
				set_beyond = (set_first >= MAX_PG);
			end
			REQ_FREE_REGION: begin
				// round inward
				set_first    = PN_W'(addr_up >> PB_LOG);
				set_stop_raw = PN_W'(end_q >> PB_LOG);
			end
			REQ_RESERVE: begin
				// round outward
				set_stop_raw = PN_W'(end_up >> PB_LOG);
			end
			default: begin
				set_beyond = 1'b0;
			end
		endcase
		set_stop    = (set_stop_raw > MAX_PG) ? MAX_PG : set_stop_raw;
		set_empty   = (set_first >= set_stop);
		set_stop_m1 = set_stop - 1'b1;
		set_first_w = WA_W'(set_first >> BIT_W);
	end

	// walk: bit range within the current entry
	logic [WA_W-1:0] first_w, last_w;
	logic            at_last;
	word_cmd_t       wcmd;
	word_res_t       wres;

	assign first_w = WA_W'(first_q >> BIT_W);
	assign last_w  = WA_W'(stop_m1_q >> BIT_W);
	assign at_last = (cur_q == last_w);

	always_comb begin
		wcmd.op = req_q;
		wcmd.lo = (cur_q == first_w) ? first_q[BIT_W-1:0] : '0;
		wcmd.hi = at_last ? stop_m1_q[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
	end

	bpa_word_alu u_word_alu (
		.cmd     (wcmd),
		.word_in (map_rdata_q),
		.res     (wres)
	);

	logic [63:0] found_addr;
	assign found_addr = 64'({cur_q, wres.idx}) << PB_LOG;

	// next state and memory control
	always_comb begin
		st_d      = st_q;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = wres.word;
		mem_re    = 1'b0;
		mem_raddr = cur_q + 1'b1;
		case (st_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {WORD_BITS{1'b1}};
				if (clr_q == LAST_WORD) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					st_d = ST_PREP;
				end
			end
			ST_PREP: begin
				st_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (set_beyond || set_empty) begin
					st_d = ST_PUSH;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = set_first_w;
					st_d      = ST_WALK;
				end
			end
			ST_WALK: begin
				if (req_q == REQ_ALLOC) begin
					mem_we = wres.found;
					if (wres.found || at_last) begin
						st_d = ST_PUSH;
					end else begin
						mem_re = 1'b1;
					end
				end else begin
					mem_we = 1'b1;
					if (at_last) begin
						st_d = ST_PUSH;
					end else begin
						mem_re = 1'b1;
					end
				end
			end
			ST_PUSH: begin
				if (push_ok) begin
					st_d = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			map_rdata_q <= map_mem[mem_raddr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_CLEAR;
			clr_q       <= '0;
			used_q      <= '0;
			total_q     <= TOTAL_PAGES_RESET;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_valid && cfg_ready) begin
				total_q <= cfg_data;
			end
			// count follows a found alloc or a page free, saturating both ways
			if (st_q == ST_WALK) begin
				if (req_q == REQ_ALLOC && wres.found && used_q != COUNT_MAX) begin
					used_q <= used_q + 1'b1;
				end else if (req_q == REQ_FREE && used_q != '0) begin
					used_q <= used_q - 1'b1;
				end
			end
			if (st_q == ST_PUSH && push_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request and result registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_q  <= req_t'(req_type);
			addr_q <= byte_address;
			len_q  <= region_len;
		end
		if (st_q == ST_PREP) begin
			// region end saturates at the top of the address space
			end_q <= sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
		end
		if (st_q == ST_SETUP) begin
			first_q      <= set_first;
			stop_m1_q    <= set_stop_m1;
			cur_q        <= set_first_w;
			res_addr_q   <= '0;
			if (set_beyond) begin
				res_status_q <= STAT_BEYOND;
			end else if (set_empty && req_q == REQ_ALLOC) begin
				res_status_q <= STAT_NO_FREE;
			end else begin
				res_status_q <= STAT_DONE;
			end
		end
		if (st_q == ST_WALK) begin
			cur_q <= cur_q + 1'b1;
			if (req_q == REQ_ALLOC) begin
				if (wres.found) begin
					res_addr_q   <= found_addr[31:0];
					res_status_q <= STAT_DONE;
				end else if (at_last) begin
					res_status_q <= STAT_NO_FREE;
				end
			end
		end
		if (st_q == ST_PUSH && push_ok) begin
			page_address_q <= res_addr_q;
			status_q       <= res_status_q;
			used_count_q   <= used_q;
		end
	end

`ifndef SYNTHESIS
	// no map write while a request could be accepted
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_IDLE) |-> !mem_we)
		else $error("map written while idle");

	// the used count only moves during a walk
	a_count_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_WALK) |=> $stable(used_q))
		else $error("used count changed outside a walk");

	// the walk never runs past the last entry of the range
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_WALK) |-> (cur_q <= last_w))
		else $error("walk beyond last entry");

	// beyond-store status belongs to page free only
	a_beyond_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PUSH && res_status_q == STAT_BEYOND) |-> (req_q == REQ_FREE))
		else $error("beyond-store status on a non-free request");

	// an accepted request always enters preparation
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (st_q == ST_PREP))
		else $error("accepted request lost");
`endif

endmodule

`default_nettype wire

// ===== sv/bpa_word_alu.sv =====
// modify one 32-bit map entry over a bit range and find its lowest free page
`default_nettype none

module bpa_word_alu (
	input  bpa_pkg::word_cmd_t cmd,
	input  logic [31:0]        word_in,
	output bpa_pkg::word_res_t res
);
	import bpa_pkg::*;

	logic [WORD_BITS-1:0] lo_mask;
	logic [WORD_BITS-1:0] hi_mask;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] lowbit;
	logic [BIT_W-1:0]     idx;

	assign lo_mask = {WORD_BITS{1'b1}} << cmd.lo;
	assign hi_mask = {WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - cmd.hi);
	assign mask    = lo_mask & hi_mask;

	// free pages inside the range, lowest one isolated
	assign cand   = ~word_in & mask;
	assign lowbit = cand & (~cand + 1'b1);

	always_comb begin
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowbit[i]) begin
				idx = idx | BIT_W'(i);
			end
		end
	end

	always_comb begin
		res.found = |cand;
		res.idx   = idx;
		case (cmd.op)
			REQ_ALLOC:       res.word = word_in | lowbit;
			REQ_FREE:        res.word = word_in & ~mask;
			REQ_FREE_REGION: res.word = word_in & ~mask;
			REQ_RESERVE:     res.word = word_in | mask;
			default:         res.word = word_in;
		endcase
	end

endmodule

`default_nettype wire
